@@ sv/w2s_pkg.sv @@
`timescale 1ns / 1ps
package w2s_pkg;

    // operation codes carried in s_tuser
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic {
        CFG_HALF_WIDTH  = 1'b0,
        CFG_HALF_HEIGHT = 1'b1
    } cfg_idx_t;

    localparam int CFG_W     = 14;
    localparam int QUOT_BITS = 41;                 // quotient bits kept, clamp is 2^40
    localparam logic [QUOT_BITS-1:0] QUOT_CLAMP = {1'b1, {(QUOT_BITS-1){1'b0}}};
    localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 14'd960;
    localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 14'd540;

endpackage

@@ sv/world_to_screen_projection.sv @@
`timescale 1ns / 1ps
// one beat per cycle while the output beat can move; the 41 one-bit divider stages set the depth
// loads write the matrix at acceptance and produce no result beat
// reset (aresetn low, synchronous): matrix cleared, half_width 960,
// half_height 540, pipeline emptied
module world_to_screen_projection
    import w2s_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [13:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68], pos_z[131:100]
    input  logic [135:0] s_tdata,
    // operation[0]
    input  logic [0:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // screen_x[31:0], screen_y[63:32]
    output logic [63:0]  m_tdata,
    // visible[0]
    output logic [0:0]   m_tuser
);

    localparam int PW = 64 - FRAC_BITS;        // floored product width
    localparam int SW = PW + 2;                // clip-space sum width
    localparam int MW = SW;                    // magnitude / divisor width
    localparam int NW = MW + FRAC_BITS;        // scaled dividend width
    localparam int QB = QUOT_BITS;
    localparam int VW = QB + 2;                // one plus signed quotient
    localparam int XW = VW + CFG_W + 1;        // viewport product width

    // global advance: the whole pipeline moves when the output beat can move
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic acc;
    assign acc = s_tvalid && s_tready;

    // config registers
    logic [CFG_W-1:0] hw_reg, hh_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg <= HALF_WIDTH_RST;
            hh_reg <= HALF_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_HALF_WIDTH:  hw_reg <= cfg_wdata;
                CFG_HALF_HEIGHT: hh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // matrix store, written by load beats
    logic [31:0] mat_reg [0:15];
    logic        is_proj;
    assign is_proj = (op_t'(s_tuser[0]) == OP_PROJECT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
        end else if (acc && !is_proj) begin
            mat_reg[s_tdata[3:0]] <= s_tdata[35:4];
        end
    end

    // stage 1: point and coefficient snapshot
    // coefficient order per column: rows 0..3; column 3 = w, 0 = x, 1 = y
    logic               v1_reg;
    logic signed [31:0] p1_reg [0:2];
    logic signed [31:0] cw1_reg [0:3], cx1_reg [0:3], cy1_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= acc && is_proj;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg[0] <= s_tdata[67:36];
            p1_reg[1] <= s_tdata[99:68];
            p1_reg[2] <= s_tdata[131:100];
            for (int r = 0; r < 4; r++) begin
                cw1_reg[r] <= mat_reg[r*4+3];
                cx1_reg[r] <= mat_reg[r*4+0];
                cy1_reg[r] <= mat_reg[r*4+1];
            end
        end
    end

    // stage 2: nine products, floored to FRAC_BITS fraction bits
    logic               v2_reg;
    logic signed [PW-1:0] pw2_reg [0:2], px2_reg [0:2], py2_reg [0:2];
    logic signed [31:0] cw2_reg, cx2_reg, cy2_reg;
    logic signed [63:0] mw [0:2], mx [0:2], my [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mw[r] = cw1_reg[r] * p1_reg[r];
            mx[r] = cx1_reg[r] * p1_reg[r];
            my[r] = cy1_reg[r] * p1_reg[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                pw2_reg[r] <= mw[r][63:FRAC_BITS];
                px2_reg[r] <= mx[r][63:FRAC_BITS];
                py2_reg[r] <= my[r][63:FRAC_BITS];
            end
            cw2_reg <= cw1_reg[3];
            cx2_reg <= cx1_reg[3];
            cy2_reg <= cy1_reg[3];
        end
    end

    // stage 3: clip-space sums
    logic                 v3_reg;
    logic signed [SW-1:0] w3_reg, x3_reg, y3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            w3_reg <= SW'(pw2_reg[0]) + SW'(pw2_reg[1]) + SW'(pw2_reg[2]) + SW'(cw2_reg);
            x3_reg <= SW'(px2_reg[0]) + SW'(px2_reg[1]) + SW'(px2_reg[2]) + SW'(cx2_reg);
            y3_reg <= SW'(py2_reg[0]) + SW'(py2_reg[1]) + SW'(py2_reg[2]) + SW'(cy2_reg);
        end
    end

    // stage 4: visibility, magnitudes, overflow check on the top dividend bits
    logic                 vis_c;
    logic [MW-1:0]        nx_c, ny_c;
    logic [NW-1:0]        dx_c, dy_c;
    logic signed [SW-1:0] one_s;

    assign one_s = SW'(1) <<< FRAC_BITS;
    assign vis_c = (w3_reg >= one_s);
    assign nx_c  = x3_reg[SW-1] ? MW'(-x3_reg) : MW'(x3_reg);
    assign ny_c  = y3_reg[SW-1] ? MW'(-y3_reg) : MW'(y3_reg);
    assign dx_c  = {nx_c, {FRAC_BITS{1'b0}}};
    assign dy_c  = {ny_c, {FRAC_BITS{1'b0}}};

    // divider pipeline, index 0 is the entry stage, one quotient bit per stage
    logic          dv_reg   [0:QB];
    logic          vis_reg  [0:QB];
    logic          negx_reg [0:QB], negy_reg [0:QB];
    logic          ovfx_reg [0:QB], ovfy_reg [0:QB];
    logic [MW-1:0] d_reg    [0:QB];
    logic [MW-1:0] rx_reg   [0:QB], ry_reg [0:QB];
    logic [QB-1:0] lx_reg   [0:QB], ly_reg [0:QB];
    logic [QB-1:0] qx_reg   [0:QB], qy_reg [0:QB];

    logic [MW:0]   tx [0:QB-1], ty [0:QB-1];
    logic          gx [0:QB-1], gy [0:QB-1];

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            tx[k] = {rx_reg[k], lx_reg[k][QB-1]};
            ty[k] = {ry_reg[k], ly_reg[k][QB-1]};
            gx[k] = (tx[k] >= {1'b0, d_reg[k]});
            gy[k] = (ty[k] >= {1'b0, d_reg[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) dv_reg[k] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= v3_reg;
            for (int k = 0; k < QB; k++) dv_reg[k+1] <= dv_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vis_reg[0]  <= vis_c;
            negx_reg[0] <= x3_reg[SW-1];
            negy_reg[0] <= y3_reg[SW-1];
            d_reg[0]    <= MW'(w3_reg);
            ovfx_reg[0] <= (MW'(dx_c[NW-1:QB]) >= MW'(w3_reg));
            ovfy_reg[0] <= (MW'(dy_c[NW-1:QB]) >= MW'(w3_reg));
            rx_reg[0]   <= MW'(dx_c[NW-1:QB]);
            ry_reg[0]   <= MW'(dy_c[NW-1:QB]);
            lx_reg[0]   <= dx_c[QB-1:0];
            ly_reg[0]   <= dy_c[QB-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            for (int k = 0; k < QB; k++) begin
                vis_reg[k+1]  <= vis_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                ovfx_reg[k+1] <= ovfx_reg[k];
                ovfy_reg[k+1] <= ovfy_reg[k];
                d_reg[k+1]    <= d_reg[k];
                rx_reg[k+1]   <= gx[k] ? MW'(tx[k] - {1'b0, d_reg[k]}) : MW'(tx[k]);
                ry_reg[k+1]   <= gy[k] ? MW'(ty[k] - {1'b0, d_reg[k]}) : MW'(ty[k]);
                lx_reg[k+1]   <= {lx_reg[k][QB-2:0], 1'b0};
                ly_reg[k+1]   <= {ly_reg[k][QB-2:0], 1'b0};
                qx_reg[k+1]   <= {qx_reg[k][QB-2:0], gx[k]};
                qy_reg[k+1]   <= {qy_reg[k][QB-2:0], gy[k]};
            end
        end
    end

    // clamp, sign and offset by one
    logic [QB-1:0]        mgx_c, mgy_c;
    logic                 ve_reg, vise_reg;
    logic signed [VW-1:0] ux_reg, uy_reg;
    logic signed [VW-1:0] one_v;

    assign one_v = VW'(1) <<< FRAC_BITS;
    assign mgx_c = (ovfx_reg[QB] || qx_reg[QB] > QUOT_CLAMP) ? QUOT_CLAMP : qx_reg[QB];
    assign mgy_c = (ovfy_reg[QB] || qy_reg[QB] > QUOT_CLAMP) ? QUOT_CLAMP : qy_reg[QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) ve_reg <= 1'b0;
        else if (adv) ve_reg <= dv_reg[QB];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            vise_reg <= vis_reg[QB];
            // x: one + q, y: one - q
            ux_reg <= negx_reg[QB] ? one_v - VW'(mgx_c) : one_v + VW'(mgx_c);
            uy_reg <= negy_reg[QB] ? one_v + VW'(mgy_c) : one_v - VW'(mgy_c);
        end
    end

    // viewport products
    logic                 vm_reg, vism_reg;
    logic signed [XW-1:0] sx_reg, sy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vm_reg <= 1'b0;
        else if (adv) vm_reg <= ve_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            vism_reg <= vise_reg;
            sx_reg   <= $signed({1'b0, hw_reg}) * ux_reg;
            sy_reg   <= $signed({1'b0, hh_reg}) * uy_reg;
        end
    end

    // saturation into the output register
    localparam logic signed [XW-1:0] S_MAX = XW'(33'sh0_7FFF_FFFF);
    localparam logic signed [XW-1:0] S_MIN = XW'(-33'sh0_8000_0000);

    logic [31:0] ox_c, oy_c;
    always_comb begin
        if (sx_reg > S_MAX)      ox_c = 32'h7FFF_FFFF;
        else if (sx_reg < S_MIN) ox_c = 32'h8000_0000;
        else                     ox_c = sx_reg[31:0];
        if (sy_reg > S_MAX)      oy_c = 32'h7FFF_FFFF;
        else if (sy_reg < S_MIN) oy_c = 32'h8000_0000;
        else                     oy_c = sy_reg[31:0];
    end

    logic        mv_reg;
    logic [63:0] md_reg;
    logic        mu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (adv) mv_reg <= vm_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            mu_reg <= vism_reg;
            md_reg <= vism_reg ? {oy_c, ox_c} : 64'd0;
        end
    end

    assign m_tvalid   = mv_reg;
    assign m_tdata    = md_reg;
    assign m_tuser[0] = mu_reg;

endmodule

@@ sv/w2s_checker.sv @@
`timescale 1ns / 1ps
module w2s_props (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    // an invisible point always reports the origin
    a_invisible_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 64'd0))
        else $error("invisible beat with nonzero coordinates");

    // input side stalls exactly when a result beat is held back
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output backpressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // a held result beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind world_to_screen_projection w2s_props u_w2s_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
